// ----- sv/arpc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache package
// Sizes, codes and the structs passed between the sequencer and the table.
// ----------------------------------------------------------------------------
package arpc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CACHE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ENTRY_CNT = CNT_W'(CACHE_ENTRIES);

  localparam logic [15:0] OP_REQUEST = 16'd1;
  localparam logic [15:0] OP_REPLY   = 16'd2;

  localparam logic OPER_PACKET = 1'b0;
  localparam logic OPER_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    CS_NONE     = 2'd0,
    CS_UPDATED  = 2'd1,
    CS_INSERTED = 2'd2,
    CS_FULL     = 2'd3
  } cache_status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [31:0]      ip;
    logic [47:0]      mac;
  } tbl_wr_t;

  typedef struct packed {
    logic        valid;
    logic [31:0] ip;
    logic [47:0] mac;
  } tbl_data_t;

endpackage

// ----- sv/arpc_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache channel interfaces
// Item, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface arpc_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [15:0] arp_opcode;
  logic [31:0] src_ip;
  logic [47:0] src_mac;
  logic [31:0] tgt_ip;
  logic [31:0] lookup_ip;

  modport source (
    output valid, operation, arp_opcode, src_ip, src_mac, tgt_ip, lookup_ip,
    input  ready
  );
  modport sink (
    input  valid, operation, arp_opcode, src_ip, src_mac, tgt_ip, lookup_ip,
    output ready
  );
endinterface

interface arpc_rsp_if;
  logic        valid;
  logic        ready;
  logic        send_reply;
  logic [47:0] reply_dest_mac;
  logic [31:0] reply_dest_ip;
  logic [1:0]  cache_status;
  logic        lookup_hit;
  logic [47:0] lookup_mac;

  modport source (
    output valid, send_reply, reply_dest_mac, reply_dest_ip, cache_status, lookup_hit,
           lookup_mac,
    input  ready
  );
  modport sink (
    input  valid, send_reply, reply_dest_mac, reply_dest_ip, cache_status, lookup_hit,
           lookup_mac,
    output ready
  );
endinterface

interface arpc_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- sv/arp_responder_with_cache_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP responder with address cache
// Answers requests for the own address and keeps a small IP/MAC cache that
// packets update and resolve queries read.
//
//   channel | dir | carries
//   req     | in  | ARP packet fields or resolve query address
//   rsp     | out | reply decision, cache status, lookup result
//   cfg     | in  | own_ip write data
//
// A scanning item reads one table entry per cycle through the single read port
// and stops at the first matching or first free entry, or after the last
// entry. A packet with an unknown opcode skips the scan. req.ready is high
// only while idle. A finished result waits in the output register while a new
// item is taken. Reset empties the cache; cfg is always ready.
// ----------------------------------------------------------------------------
module arp_responder_with_cache_core
  import arpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  arpc_req_if.sink   req,
  arpc_rsp_if.source rsp,
  arpc_cfg_if.sink   cfg
);

  tbl_rd_t   tbl_rd;
  tbl_wr_t   tbl_wr;
  tbl_data_t tbl_data;

  arpc_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .rsp      (rsp),
    .cfg      (cfg),
    .tbl_rd   (tbl_rd),
    .tbl_wr   (tbl_wr),
    .tbl_data (tbl_data)
  );

  arpc_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd      (tbl_rd),
    .wr      (tbl_wr),
    .rd_data (tbl_data)
  );

endmodule

// ----- sv/arpc_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache table
// IP/MAC entry memory with one write and one registered read port per cycle,
// plus per-entry valid flags cleared by reset.
// ----------------------------------------------------------------------------
module arpc_table
  import arpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  tbl_rd_t   rd,
  input  tbl_wr_t   wr,
  output tbl_data_t rd_data
);

  logic [31:0]              mem_ip  [CACHE_ENTRIES];
  logic [47:0]              mem_mac [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] entry_valid;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_ip[wr.addr]  <= wr.ip;
      mem_mac[wr.addr] <= wr.mac;
    end
    if (rd.en) begin
      rd_data.ip  <= mem_ip[rd.addr];
      rd_data.mac <= mem_mac[rd.addr];
    end
    if (rst) begin
      entry_valid   <= '0;
      rd_data.valid <= 1'b0;
    end else begin
      if (wr.en) begin
        entry_valid[wr.addr] <= 1'b1;
      end
      if (rd.en) begin
        rd_data.valid <= entry_valid[rd.addr];
      end
    end
  end

endmodule

// ----- sv/arpc_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache sequencer
// Takes one item, scans the table one entry per cycle through a shared address
// comparator, updates or fills a packet's entry, and registers the result.
// ----------------------------------------------------------------------------
module arpc_seq
  import arpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  arpc_req_if.sink   req,
  arpc_rsp_if.source rsp,
  arpc_cfg_if.sink   cfg,
  output tbl_rd_t    tbl_rd,
  output tbl_wr_t    tbl_wr,
  input  tbl_data_t  tbl_data
);

  state_t           state, state_next;
  logic [31:0]      own_ip;
  logic             is_query;
  logic             send;
  logic [31:0]      key_ip;
  logic [47:0]      key_mac;
  logic [CNT_W-1:0] rd_cnt, rd_cnt_next;
  logic             cmp_vld, cmp_vld_next;
  logic [IDX_W-1:0] cmp_idx, cmp_idx_next;
  cache_status_t    status;
  logic             hit;
  logic [47:0]      lmac;

  logic accept, scan_item, ip_match, cmp_hit, cmp_free, cmp_end, stop, issue, load_out;

  assign cfg.ready = 1'b1;
  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign scan_item = (req.operation == OPER_QUERY) || (req.arp_opcode == OP_REQUEST) ||
                     (req.arp_opcode == OP_REPLY);

  assign ip_match = (tbl_data.ip == key_ip);
  assign cmp_hit  = cmp_vld && tbl_data.valid && ip_match;
  assign cmp_free = cmp_vld && !tbl_data.valid;
  assign cmp_end  = cmp_vld && tbl_data.valid && !ip_match && (cmp_idx == LAST_IDX);
  assign stop     = cmp_hit || cmp_free || cmp_end;
  assign issue    = (state == ST_SCAN) && !stop && (rd_cnt < ENTRY_CNT);
  assign load_out = (state == ST_DONE) && (!rsp.valid || rsp.ready);

  assign tbl_rd.en   = issue;
  assign tbl_rd.addr = rd_cnt[IDX_W-1:0];

  assign tbl_wr.en   = (state == ST_SCAN) && !is_query && (cmp_hit || cmp_free);
  assign tbl_wr.addr = cmp_idx;
  assign tbl_wr.ip   = key_ip;
  assign tbl_wr.mac  = key_mac;

  always_comb begin
    state_next   = state;
    rd_cnt_next  = rd_cnt;
    cmp_vld_next = issue;
    cmp_idx_next = cmp_idx;
    if (issue) begin
      rd_cnt_next  = rd_cnt + CNT_W'(1);
      cmp_idx_next = rd_cnt[IDX_W-1:0];
    end
    unique case (state)
      ST_IDLE: begin
        rd_cnt_next = '0;
        if (accept) begin
          state_next = scan_item ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (stop) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      own_ip  <= '0;
      rd_cnt  <= '0;
      cmp_vld <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_cnt  <= rd_cnt_next;
      cmp_vld <= cmp_vld_next;
      if (cfg.valid) begin
        own_ip <= cfg.data;
      end
      if (load_out) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= cmp_idx_next;
    if (accept) begin
      is_query <= req.operation;
      send     <= (req.operation == OPER_PACKET) && (req.arp_opcode == OP_REQUEST) &&
                  (req.tgt_ip == own_ip);
      key_ip   <= (req.operation == OPER_QUERY) ? req.lookup_ip : req.src_ip;
      key_mac  <= req.src_mac;
      status   <= CS_NONE;
      hit      <= 1'b0;
      lmac     <= '0;
    end else if ((state == ST_SCAN) && stop) begin
      if (is_query) begin
        hit  <= cmp_hit;
        lmac <= cmp_hit ? tbl_data.mac : 48'd0;
      end else begin
        priority if (cmp_hit) begin
          status <= CS_UPDATED;
        end else if (cmp_free) begin
          status <= CS_INSERTED;
        end else begin
          status <= CS_FULL;
        end
      end
    end
    if (load_out) begin
      rsp.send_reply     <= send;
      rsp.reply_dest_mac <= send ? key_mac : 48'd0;
      rsp.reply_dest_ip  <= send ? key_ip : 32'd0;
      rsp.cache_status   <= status;
      rsp.lookup_hit     <= hit;
      rsp.lookup_mac     <= lmac;
    end
  end

endmodule

// ----- sv/arpc_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ARP cache port checker
// Port-level properties of the responder, attached to the top level.
// ----------------------------------------------------------------------------
module arpc_checker
  import arpc_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic        send_reply,
  input logic [1:0]  cache_status,
  input logic        lookup_hit,
  input logic [47:0] lookup_mac
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(cache_status) && $stable(lookup_mac))
    else $error("result changed while stalled");

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("item taken while busy");

  a_reply_updates: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && send_reply |-> cache_status != CS_NONE)
    else $error("reply without cache update");

  a_hit_is_query: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && lookup_hit |-> cache_status == CS_NONE && !send_reply)
    else $error("lookup hit on a packet result");

  a_miss_zero_mac: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !lookup_hit |-> lookup_mac == 48'd0)
    else $error("lookup mac without hit");

endmodule

bind arp_responder_with_cache_core arpc_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req.valid),
  .req_ready    (req.ready),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .send_reply   (rsp.send_reply),
  .cache_status (rsp.cache_status),
  .lookup_hit   (rsp.lookup_hit),
  .lookup_mac   (rsp.lookup_mac)
);
